// ----- rtl/sonar_echo_range_to_duty_top_macros.svh -----
// Assertion macros shared by the sonar echo ranging RTL.
`ifndef SONAR_ECHO_RANGE_TO_DUTY_TOP_MACROS_SVH
`define SONAR_ECHO_RANGE_TO_DUTY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SERD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SERD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/serd_pkg.sv -----
// Types and constants shared by the sonar echo ranging modules.
package serd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TIMEOUT_US     = 3'd0;
    localparam logic [2:0] CFG_DECIMATE_EDGES = 3'd1;
    localparam logic [2:0] CFG_CONFIRM_HITS   = 3'd2;
    localparam logic [2:0] CFG_NEAR_MIN       = 3'd3;
    localparam logic [2:0] CFG_NEAR_MID_EDGE  = 3'd4;
    localparam logic [2:0] CFG_MID_FAR_EDGE   = 3'd5;
    localparam logic [2:0] CFG_FAR_MAX        = 3'd6;

    // Band codes.
    localparam logic [1:0] BAND_NONE = 2'd0;
    localparam logic [1:0] BAND_NEAR = 2'd1;
    localparam logic [1:0] BAND_MID  = 2'd2;
    localparam logic [1:0] BAND_FAR  = 2'd3;

    // Duty levels.
    localparam logic [6:0] DUTY_OFF  = 7'd0;
    localparam logic [6:0] DUTY_NEAR = 7'd100;
    localparam logic [6:0] DUTY_MID  = 7'd75;
    localparam logic [6:0] DUTY_FAR  = 7'd50;

    localparam logic [3:0] RUN_MAX = 4'd15;

    // Division by 147 as a multiply by ceil(2^23 / 147). The error term
    // 94 * 65535 stays below 2^23, so the quotient is exact for 16-bit widths.
    localparam logic [15:0] DIV_RECIP = 16'd57066;
    localparam int          DIV_SHIFT = 23;

    typedef struct packed {
        logic [15:0] timeout_us;
        logic [3:0]  decimate_edges;
        logic [3:0]  confirm_hits;
        logic [8:0]  near_min;
        logic [8:0]  near_mid_edge;
        logic [8:0]  mid_far_edge;
        logic [8:0]  far_max;
    } serd_cfg_t;

    // Flow control of one pipeline stage: load a new item, or let the
    // held item go downstream.
    typedef struct packed {
        logic load;
        logic drain;
    } serd_flow_t;

endpackage

// ----- rtl/serd_edge_timer.sv -----
// Edge timing stage: arming, start stamp, width, timeout and decimation.
module serd_edge_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  serd_pkg::serd_flow_t  flow,
    input  serd_pkg::serd_cfg_t   cfg,
    input  logic [31:0]           time_us,
    output logic                  eval_valid,
    output logic [15:0]           eval_width
);
    import serd_pkg::*;

    logic        armed_reg, armed_next;
    logic        parity_reg, parity_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] held_reg, held_next;
    logic [3:0]  count_reg, count_next;
    logic        valid_reg, valid_next;
    logic [31:0] width;
    logic [3:0]  count_inc;
    logic        timed_out;
    logic        hit_eval;

    always_comb
    begin
        armed_next  = armed_reg;
        parity_next = parity_reg;
        stamp_next  = stamp_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        valid_next  = valid_reg & ~flow.drain;

        parity_next = ~parity_reg;
        width       = parity_next ? (time_us - stamp_reg) : {16'd0, held_reg};
        timed_out   = (width >= {16'd0, cfg.timeout_us});
        count_inc   = count_reg + 4'd1;
        hit_eval    = (count_inc == cfg.decimate_edges);
        parity_next = parity_reg;

        if (flow.load)
        begin
            if (!armed_reg)
            begin
                armed_next = 1'b1;
                valid_next = 1'b0;
            end
            else
            begin
                parity_next = ~parity_reg;
                if (!parity_next)
                begin
                    stamp_next = time_us;
                end
                armed_next = ~timed_out;
                held_next  = timed_out ? 16'd0 : width[15:0];
                count_next = hit_eval ? 4'd0 : count_inc;
                valid_next = hit_eval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            parity_reg <= 1'b1;
            stamp_reg  <= 32'd0;
            held_reg   <= 16'd0;
            count_reg  <= 4'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg  <= armed_next;
            parity_reg <= parity_next;
            stamp_reg  <= stamp_next;
            held_reg   <= held_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    assign eval_valid = valid_reg;
    assign eval_width = held_reg;

endmodule

// ----- rtl/serd_range_band.sv -----
// Range stage: distance by constant divide, band sorting, hit runs and duty.
module serd_range_band (
    input  logic                  clk,
    input  logic                  rst_n,
    input  serd_pkg::serd_flow_t  flow,
    input  serd_pkg::serd_cfg_t   cfg,
    input  logic [15:0]           width,
    output logic                  res_valid,
    output logic [8:0]            distance,
    output logic [1:0]            band,
    output logic [6:0]            duty
);
    import serd_pkg::*;

    logic [31:0] product;
    logic [8:0]  quotient;
    logic        in_near, in_mid, in_far;
    logic [3:0]  near_bump, mid_bump, far_bump;

    logic       valid_reg, valid_next;
    logic [8:0] dist_reg, dist_next;
    logic [1:0] band_reg, band_next;
    logic [3:0] near_run_reg, near_run_next;
    logic [3:0] mid_run_reg, mid_run_next;
    logic [3:0] far_run_reg, far_run_next;
    logic [6:0] duty_reg, duty_next;

    assign product  = 32'(width) * 32'(DIV_RECIP);
    assign quotient = product[DIV_SHIFT +: 9];

    assign in_near = (quotient >= cfg.near_min) && (quotient < cfg.near_mid_edge);
    assign in_mid  = (quotient >= cfg.near_mid_edge) && (quotient < cfg.mid_far_edge);
    assign in_far  = (quotient >= cfg.mid_far_edge) && (quotient <= cfg.far_max);

    assign near_bump = (near_run_reg == RUN_MAX) ? RUN_MAX : near_run_reg + 4'd1;
    assign mid_bump  = (mid_run_reg == RUN_MAX) ? RUN_MAX : mid_run_reg + 4'd1;
    assign far_bump  = (far_run_reg == RUN_MAX) ? RUN_MAX : far_run_reg + 4'd1;

    always_comb
    begin
        valid_next    = valid_reg & ~flow.drain;
        dist_next     = dist_reg;
        band_next     = band_reg;
        near_run_next = near_run_reg;
        mid_run_next  = mid_run_reg;
        far_run_next  = far_run_reg;
        duty_next     = duty_reg;

        if (flow.load)
        begin
            valid_next = 1'b1;
            dist_next  = quotient;
            if (in_near)
            begin
                band_next     = BAND_NEAR;
                near_run_next = near_bump;
                mid_run_next  = 4'd0;
                far_run_next  = 4'd0;
                if (near_bump >= cfg.confirm_hits)
                begin
                    duty_next = DUTY_NEAR;
                end
            end
            else if (in_mid)
            begin
                band_next     = BAND_MID;
                mid_run_next  = mid_bump;
                near_run_next = 4'd0;
                far_run_next  = 4'd0;
                if (mid_bump >= cfg.confirm_hits)
                begin
                    duty_next = DUTY_MID;
                end
            end
            else if (in_far)
            begin
                band_next     = BAND_FAR;
                far_run_next  = far_bump;
                near_run_next = 4'd0;
                mid_run_next  = 4'd0;
                if (far_bump >= cfg.confirm_hits)
                begin
                    duty_next = DUTY_FAR;
                end
            end
            else
            begin
                band_next = BAND_NONE;
                duty_next = DUTY_OFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            near_run_reg <= 4'd0;
            mid_run_reg  <= 4'd0;
            far_run_reg  <= 4'd0;
            duty_reg     <= DUTY_OFF;
        end
        else
        begin
            valid_reg    <= valid_next;
            near_run_reg <= near_run_next;
            mid_run_reg  <= mid_run_next;
            far_run_reg  <= far_run_next;
            duty_reg     <= duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        band_reg <= band_next;
    end

    assign res_valid = valid_reg;
    assign distance  = dist_reg;
    assign band      = band_reg;
    assign duty      = duty_reg;

endmodule

// ----- rtl/sonar_echo_range_to_duty_top.sv -----
// Top level of the sonar echo ranging block: ports, configuration and pipeline control.
// Path: input register, edge timing register, then result register to the master side.
// Throughput: one request per cycle, bounded only by m_tready; the edge timing stage
// updates its state once per request, the range stage once per evaluation passed on.
// Reset: rst_n clears the control state asynchronously; it comes up disarmed with the
// documented register defaults (timeout 30000, decimation 5, confirm 3, bands 7/18/37/50).
`include "sonar_echo_range_to_duty_top_macros.svh"

module sonar_echo_range_to_duty_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: tdata[31:0] = time_us.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Result stream: tdata[8:0] = distance, [10:9] = band, [17:11] = duty,
    // [23:18] = zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import serd_pkg::*;

    // The pipeline has three registers: the input register, the edge timing
    // register and the result register. Each one may take a new request when
    // it is empty or when its content moves on in the same cycle, so the
    // ready chain runs back from m_tready through all three.

    serd_cfg_t   cfg_reg, cfg_next;

    logic        in_valid_reg, in_valid_next;
    logic [31:0] in_time_reg;

    logic        eval_valid;
    logic [15:0] eval_width;
    logic        res_valid;
    logic [8:0]  distance;
    logic [1:0]  band;
    logic [6:0]  duty;

    logic        out_free;
    logic        eval_free;
    logic        in_free;
    serd_flow_t  timer_flow;
    serd_flow_t  range_flow;

    assign out_free  = ~res_valid | m_tready;
    assign eval_free = ~eval_valid | out_free;
    assign in_free   = ~in_valid_reg | eval_free;

    assign s_tready  = in_free;
    assign cfg_ready = 1'b1;

    // The timing stage consumes the input register when it has room; its own
    // held evaluation drains whenever the range stage can take it.
    assign timer_flow.load  = in_valid_reg & eval_free;
    assign timer_flow.drain = out_free;

    assign range_flow.load  = eval_valid & out_free;
    assign range_flow.drain = m_tready;

    // Configuration registers. Writes must arrive only while the block is idle;
    // this is not enforced. Stages read them directly; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT_US:     cfg_next.timeout_us     = cfg_data;
                CFG_DECIMATE_EDGES: cfg_next.decimate_edges = cfg_data[3:0];
                CFG_CONFIRM_HITS:   cfg_next.confirm_hits   = cfg_data[3:0];
                CFG_NEAR_MIN:       cfg_next.near_min       = cfg_data[8:0];
                CFG_NEAR_MID_EDGE:  cfg_next.near_mid_edge  = cfg_data[8:0];
                CFG_MID_FAR_EDGE:   cfg_next.mid_far_edge   = cfg_data[8:0];
                CFG_FAR_MAX:        cfg_next.far_max        = cfg_data[8:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_us     <= 16'd30000;
            cfg_reg.decimate_edges <= 4'd5;
            cfg_reg.confirm_hits   <= 4'd3;
            cfg_reg.near_min       <= 9'd7;
            cfg_reg.near_mid_edge  <= 9'd18;
            cfg_reg.mid_far_edge   <= 9'd37;
            cfg_reg.far_max        <= 9'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: it fills on an accepted request and empties when the
    // timing stage takes the request without a new one arriving.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && in_free)
        begin
            in_valid_next = 1'b1;
        end
        else if (timer_flow.load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_free)
        begin
            in_time_reg <= s_tdata;
        end
    end

    serd_edge_timer u_edge_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .flow       (timer_flow),
        .cfg        (cfg_reg),
        .time_us    (in_time_reg),
        .eval_valid (eval_valid),
        .eval_width (eval_width)
    );

    serd_range_band u_range_band (
        .clk       (clk),
        .rst_n     (rst_n),
        .flow      (range_flow),
        .cfg       (cfg_reg),
        .width     (eval_width),
        .res_valid (res_valid),
        .distance  (distance),
        .band      (band),
        .duty      (duty)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {6'd0, duty, band, distance};

    // A stalled input side can only come from a full pipeline held by the sink.
    `SERD_ASSERT_NOW(a_stall_source, !s_tready, m_tvalid && !m_tready,
        "input stalled without a held result")
    // A result outside every band always turns the feedback off.
    `SERD_ASSERT_NOW(a_none_is_off, m_tvalid && (band == BAND_NONE), duty == DUTY_OFF,
        "duty not zero outside the bands")
    // The duty only takes one of its four levels.
    `SERD_ASSERT_NOW(a_duty_level, m_tvalid,
        (duty == DUTY_OFF) || (duty == DUTY_NEAR) || (duty == DUTY_MID) || (duty == DUTY_FAR),
        "duty off its levels")
    // A 16-bit width divided by 147 never exceeds 445.
    `SERD_ASSERT_NOW(a_dist_range, m_tvalid, distance <= 9'd445,
        "distance out of range")
    // A held evaluation that the range stage takes turns into a result next cycle.
    `SERD_ASSERT_NEXT(a_eval_to_result, range_flow.load, m_tvalid,
        "evaluation lost between stages")

endmodule
